/* sv/process_table_priority_scheduler_core_defines.svh */
// Assertion macros for the task scheduler block.
// Included by the top level only; no other dependencies.
`ifndef PROCESS_TABLE_PRIORITY_SCHEDULER_CORE_DEFINES_SVH
`define PROCESS_TABLE_PRIORITY_SCHEDULER_CORE_DEFINES_SVH

// Condition b holds in the same cycle as a.
`define PTPS_ASSERT_SAME(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Condition b holds in the cycle after a.
`define PTPS_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

/* sv/ptps_pkg.sv */
// Shared types for the task scheduler: event codes, result codes, task
// states and the command and status bundles between controller and datapath.
`default_nettype none
package ptps_pkg;

  typedef enum logic [2:0] {
    OP_INIT = 3'd0,
    OP_TICK = 3'd1,
    OP_FORK = 3'd2,
    OP_EXIT = 3'd3,
    OP_WAIT = 3'd4,
    OP_NICE = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_NO_FREE  = 3'd1,
    ST_NO_CHILD = 3'd2,
    ST_REAPED   = 3'd3,
    ST_NO_READY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    TS_READY  = 2'd0,
    TS_RUN    = 2'd1,
    TS_SLEEP  = 2'd2,
    TS_ZOMBIE = 2'd3
  } task_state_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_INIT,
    CMD_TICK,
    CMD_SCAN_CLR,
    CMD_SCAN_STEP,
    CMD_FORK,
    CMD_EXIT,
    CMD_REAP,
    CMD_SLEEP,
    CMD_NICE,
    CMD_RS_CLR,
    CMD_RS_NEXT,
    CMD_DIV_START,
    CMD_DIV_STEP,
    CMD_PRIO,
    CMD_APPLY,
    CMD_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_ACT,
    S_RS_SLOT,
    S_RS_DIV,
    S_RS_PRIO,
    S_APPLY,
    S_DONE
  } fsm_t;

  typedef struct packed {
    dp_op_t  op;
    logic    set_st;
    status_t st;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic cur_ok;
    logic cur_run;
    logic par_sleep;
    logic idx_last;
    logic idx_valid;
    logic free_found;
    logic zomb_found;
    logic has_child;
    logic div_done;
    logic pick_found;
  } dp_stat_t;

  localparam logic signed [7:0] PRIO_INIT = 8'sd20;
  localparam logic signed [7:0] PRIO_MIN  = -8'sd128;
  localparam logic signed [7:0] NICE_MAX  = 8'sd19;
  localparam logic signed [7:0] NICE_MIN  = -8'sd20;
  localparam logic signed [6:0] NICE_BASE = 7'sd20;

endpackage
`default_nettype wire

/* sv/process_table_priority_scheduler_core.sv */
// Task table with a nice-based priority scheduler. An event is taken when
// start is high and busy is low; its single result appears for one cycle
// with out_valid and cannot be held off. Init, nice, unused codes and
// refused events go from dispatch straight to the result; fork, wait that
// reaps or finds no child, and exit to a sleeping parent first scan every
// slot. Events that reschedule (tick, exit to a parent that is not
// sleeping, wait that sleeps) walk every slot and pass each occupied slot
// through one shared bit-serial divider; a wait that sleeps scans the slots
// first. busy drops on the cycle the result shows.
`default_nettype none
`include "process_table_priority_scheduler_core_defines.svh"
module process_table_priority_scheduler_core #(
  parameter int SLOTS      = 16,
  parameter int TICK_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_opcode,
  input  wire logic signed [7:0] in_nice_value,
  input  wire logic [7:0]        in_exit_value,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [4:0]             out_new_pid,
  output logic [4:0]             out_reaped_pid,
  output logic [7:0]             out_reaped_code,
  output logic [4:0]             out_running_pid,
  output logic [4:0]             out_running_parent,
  output logic                   out_switched,
  output logic [31:0]            out_all_ticks,
  output logic [31:0]            out_running_ticks,
  output logic [4:0]             out_live_tasks
);

  ptps_pkg::dp_cmd_t  cmd;
  ptps_pkg::dp_stat_t stat;

  ptps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ptps_dp #(
    .SLOTS      (SLOTS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_opcode),
    .in_nice_value      (in_nice_value),
    .in_exit_value      (in_exit_value),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_new_pid        (out_new_pid),
    .out_reaped_pid     (out_reaped_pid),
    .out_reaped_code    (out_reaped_code),
    .out_running_pid    (out_running_pid),
    .out_running_parent (out_running_parent),
    .out_switched       (out_switched),
    .out_all_ticks      (out_all_ticks),
    .out_running_ticks  (out_running_ticks),
    .out_live_tasks     (out_live_tasks)
  );

  `PTPS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted transaction did not raise busy")
  `PTPS_ASSERT_NEXT(a_one_strobe, clk, rst_n, out_valid, !out_valid, "result strobe lasted more than one cycle")
  `PTPS_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_valid, !busy, "result shown while still busy")
  `PTPS_ASSERT_SAME(a_no_task_ticks, clk, rst_n, out_valid && out_running_pid == 5'd0, out_running_ticks == 32'd0 && out_running_parent == 5'd0, "ticks reported without a current task")

endmodule
`default_nettype wire

/* sv/ptps_ctrl.sv */
// Controller state machine of the task scheduler.
// Depends on ptps_pkg; drives ptps_dp through command and status bundles.
`default_nettype none
module ptps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ptps_pkg::dp_stat_t stat,
  output ptps_pkg::dp_cmd_t      cmd
);

  ptps_pkg::fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptps_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ptps_pkg::S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = ptps_pkg::CMD_NONE;
    cmd.set_st = 1'b0;
    cmd.st     = ptps_pkg::ST_DONE;
    case (state_r)
      ptps_pkg::S_IDLE: begin
        if (start) begin
          cmd.op    = ptps_pkg::CMD_LATCH;
          state_nxt = ptps_pkg::S_DISPATCH;
        end
      end
      ptps_pkg::S_DISPATCH: begin
        state_nxt = ptps_pkg::S_DONE;
        if (stat.op == ptps_pkg::OP_INIT) begin
          cmd.op = ptps_pkg::CMD_INIT;
        end else if (stat.op == ptps_pkg::OP_TICK) begin
          cmd.op = ptps_pkg::CMD_TICK;
          if (!stat.cur_ok) begin
            cmd.set_st = 1'b1;
            cmd.st     = ptps_pkg::ST_NO_READY;
          end else begin
            state_nxt = ptps_pkg::S_APPLY;
            cmd.op    = ptps_pkg::CMD_TICK;
          end
        end else if ((stat.op == ptps_pkg::OP_FORK || stat.op == ptps_pkg::OP_EXIT ||
                      stat.op == ptps_pkg::OP_WAIT || stat.op == ptps_pkg::OP_NICE) &&
                     !stat.cur_run) begin
          cmd.set_st = 1'b1;
          cmd.st     = ptps_pkg::ST_NO_READY;
        end else begin
          case (stat.op)
            ptps_pkg::OP_FORK, ptps_pkg::OP_WAIT: begin
              cmd.op    = ptps_pkg::CMD_SCAN_CLR;
              state_nxt = ptps_pkg::S_SCAN;
            end
            ptps_pkg::OP_EXIT: begin
              cmd.op    = ptps_pkg::CMD_EXIT;
              state_nxt = stat.par_sleep ? ptps_pkg::S_SCAN : ptps_pkg::S_APPLY;
            end
            ptps_pkg::OP_NICE: cmd.op = ptps_pkg::CMD_NICE;
            default: cmd.op = ptps_pkg::CMD_NONE;
          endcase
        end
        // The reschedule pass starts from a cleared pick; S_APPLY is reused
        // here as the entry point and is redirected just below.
        if (state_nxt == ptps_pkg::S_APPLY) begin
          state_nxt = ptps_pkg::S_RS_SLOT;
        end
      end
      ptps_pkg::S_SCAN: begin
        cmd.op = ptps_pkg::CMD_SCAN_STEP;
        if (stat.idx_last) begin
          state_nxt = ptps_pkg::S_ACT;
        end
      end
      ptps_pkg::S_ACT: begin
        state_nxt = ptps_pkg::S_DONE;
        case (stat.op)
          ptps_pkg::OP_FORK: begin
            if (stat.free_found) begin
              cmd.op = ptps_pkg::CMD_FORK;
            end else begin
              cmd.set_st = 1'b1;
              cmd.st     = ptps_pkg::ST_NO_FREE;
            end
          end
          ptps_pkg::OP_WAIT: begin
            if (!stat.has_child) begin
              cmd.set_st = 1'b1;
              cmd.st     = ptps_pkg::ST_NO_CHILD;
            end else if (stat.zomb_found) begin
              cmd.op     = ptps_pkg::CMD_REAP;
              cmd.set_st = 1'b1;
              cmd.st     = ptps_pkg::ST_REAPED;
            end else begin
              cmd.op    = ptps_pkg::CMD_SLEEP;
              state_nxt = ptps_pkg::S_RS_SLOT;
            end
          end
          default: begin
            if (stat.zomb_found) begin
              cmd.op     = ptps_pkg::CMD_REAP;
              cmd.set_st = 1'b1;
              cmd.st     = ptps_pkg::ST_REAPED;
            end
          end
        endcase
      end
      ptps_pkg::S_RS_SLOT: begin
        if (stat.idx_valid) begin
          cmd.op    = ptps_pkg::CMD_DIV_START;
          state_nxt = ptps_pkg::S_RS_DIV;
        end else if (stat.idx_last) begin
          state_nxt = ptps_pkg::S_APPLY;
        end else begin
          cmd.op = ptps_pkg::CMD_RS_NEXT;
        end
      end
      ptps_pkg::S_RS_DIV: begin
        if (stat.div_done) begin
          state_nxt = ptps_pkg::S_RS_PRIO;
        end else begin
          cmd.op = ptps_pkg::CMD_DIV_STEP;
        end
      end
      ptps_pkg::S_RS_PRIO: begin
        cmd.op    = ptps_pkg::CMD_PRIO;
        state_nxt = stat.idx_last ? ptps_pkg::S_APPLY : ptps_pkg::S_RS_SLOT;
      end
      ptps_pkg::S_APPLY: begin
        cmd.op    = ptps_pkg::CMD_APPLY;
        state_nxt = ptps_pkg::S_DONE;
        if (!stat.pick_found) begin
          cmd.set_st = 1'b1;
          cmd.st     = ptps_pkg::ST_NO_READY;
        end
      end
      ptps_pkg::S_DONE: begin
        cmd.op    = ptps_pkg::CMD_EMIT;
        state_nxt = ptps_pkg::S_IDLE;
      end
      default: state_nxt = ptps_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* sv/ptps_dp.sv */
// Datapath of the task scheduler: task table, counters, a bit-serial
// divider for the priority formula and the result registers. Uses ptps_pkg.
`default_nettype none
module ptps_dp #(
  parameter int SLOTS      = 16,
  parameter int TICK_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ptps_pkg::dp_cmd_t  cmd,
  output ptps_pkg::dp_stat_t      stat,
  input  wire logic [2:0]         in_opcode,
  input  wire logic signed [7:0]  in_nice_value,
  input  wire logic [7:0]         in_exit_value,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [4:0]              out_new_pid,
  output logic [4:0]              out_reaped_pid,
  output logic [7:0]              out_reaped_code,
  output logic [4:0]              out_running_pid,
  output logic [4:0]              out_running_parent,
  output logic                    out_switched,
  output logic [31:0]             out_all_ticks,
  output logic [31:0]             out_running_ticks,
  output logic [4:0]              out_live_tasks
);

  localparam int SW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam int CW = $clog2(TICK_WIDTH + 1);

  logic [SLOTS-1:0]            valid_r;
  logic [PW-1:0]               parent_r [SLOTS];
  ptps_pkg::task_state_t       tstate_r [SLOTS];
  logic signed [5:0]           nice_r   [SLOTS];
  logic [TICK_WIDTH-1:0]       ticks_r  [SLOTS];
  logic [7:0]                  code_r   [SLOTS];

  logic [SW-1:0]               cur_r, before_r, idx_r;
  logic [TICK_WIDTH-1:0]       gt_r;
  logic [PW-1:0]               live_r;

  ptps_pkg::op_t               op_r;
  logic signed [7:0]           nv_r;
  logic [7:0]                  exit_code_r;
  ptps_pkg::status_t           st_r;
  logic [PW-1:0]               new_pid_r, reaped_pid_r;
  logic [7:0]                  reaped_code_r;

  logic                        free_found_r, zomb_found_r, has_child_r;
  logic [SW-1:0]               free_idx_r, zomb_idx_r;

  logic [TICK_WIDTH-1:0]       dvd_r;
  logic [6:0]                  rem_r;
  logic [5:0]                  base_r;
  logic [CW-1:0]               cnt_r;
  logic signed [7:0]           best_r;
  logic                        pick_found_r;
  logic [SW-1:0]               pick_r;

  logic                        out_valid_r;
  logic [2:0]                  o_status_r;
  logic [4:0]                  o_new_r, o_rpid_r, o_rpar_r, o_rpid_cur_r, o_live_r;
  logic [7:0]                  o_rcode_r;
  logic                        o_sw_r;
  logic [31:0]                 o_gt_r, o_rt_r;

  logic [PW-1:0]               cur_pid, par;
  logic [SW-1:0]               par_idx;
  logic                        cur_ok, cur_run, par_sleep, idx_last;
  logic [6:0]                  trial;
  logic signed [6:0]           base_wide;
  logic                        sat;
  logic signed [7:0]           prio;
  logic                        eligible;

  assign cur_pid   = PW'(cur_r) + PW'(1);
  assign cur_ok    = valid_r[cur_r];
  assign cur_run   = cur_ok && (tstate_r[cur_r] == ptps_pkg::TS_RUN);
  assign par       = parent_r[cur_r];
  assign par_idx   = SW'(par - PW'(1));
  assign par_sleep = (par != '0) && valid_r[par_idx] &&
                     (tstate_r[par_idx] == ptps_pkg::TS_SLEEP);
  assign idx_last  = (idx_r == SW'(SLOTS - 1));

  assign trial     = {rem_r[5:0], dvd_r[TICK_WIDTH-1]};
  assign base_wide = ptps_pkg::NICE_BASE - {nice_r[idx_r][5], nice_r[idx_r]};
  assign sat       = {1'b0, dvd_r} >= ((TICK_WIDTH+1)'(base_r) + (TICK_WIDTH+1)'(128));
  assign prio      = sat ? ptps_pkg::PRIO_MIN : (8'(base_r) - 8'(dvd_r));
  assign eligible  = (tstate_r[idx_r] == ptps_pkg::TS_READY) ||
                     ((idx_r == cur_r) && (tstate_r[idx_r] == ptps_pkg::TS_RUN));

  always_comb begin
    stat.op         = op_r;
    stat.cur_ok     = cur_ok;
    stat.cur_run    = cur_run;
    stat.par_sleep  = par_sleep;
    stat.idx_last   = idx_last;
    stat.idx_valid  = valid_r[idx_r];
    stat.free_found = free_found_r;
    stat.zomb_found = zomb_found_r;
    stat.has_child  = has_child_r;
    stat.div_done   = (cnt_r == CW'(TICK_WIDTH));
    stat.pick_found = pick_found_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cur_r       <= '0;
      gt_r        <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.set_st) begin
        st_r <= cmd.st;
      end
      case (cmd.op)
        ptps_pkg::CMD_LATCH: begin
          op_r          <= ptps_pkg::op_t'(in_opcode);
          nv_r          <= in_nice_value;
          exit_code_r   <= in_exit_value;
          st_r          <= ptps_pkg::ST_DONE;
          new_pid_r     <= '0;
          reaped_pid_r  <= '0;
          reaped_code_r <= '0;
          before_r      <= cur_r;
        end
        ptps_pkg::CMD_INIT: begin
          valid_r      <= SLOTS'(1);
          parent_r[0]  <= '0;
          tstate_r[0]  <= ptps_pkg::TS_RUN;
          nice_r[0]    <= '0;
          ticks_r[0]   <= '0;
          code_r[0]    <= '0;
          cur_r        <= '0;
          before_r     <= '0;
          gt_r         <= '0;
          live_r       <= PW'(1);
        end
        ptps_pkg::CMD_TICK: begin
          gt_r         <= gt_r + TICK_WIDTH'(1);
          if (cur_run) begin
            ticks_r[cur_r] <= ticks_r[cur_r] + TICK_WIDTH'(1);
          end
          idx_r        <= '0;
          best_r       <= '0;
          pick_found_r <= 1'b0;
        end
        ptps_pkg::CMD_SCAN_CLR: begin
          idx_r        <= '0;
          free_found_r <= 1'b0;
          zomb_found_r <= 1'b0;
          has_child_r  <= 1'b0;
        end
        ptps_pkg::CMD_SCAN_STEP: begin
          idx_r <= idx_r + SW'(1);
          if (!valid_r[idx_r] && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= idx_r;
          end
          if (valid_r[idx_r] && parent_r[idx_r] == cur_pid) begin
            if (idx_r != cur_r) begin
              has_child_r <= 1'b1;
            end
            if (tstate_r[idx_r] == ptps_pkg::TS_ZOMBIE && !zomb_found_r) begin
              zomb_found_r <= 1'b1;
              zomb_idx_r   <= idx_r;
            end
          end
        end
        ptps_pkg::CMD_FORK: begin
          valid_r[free_idx_r]  <= 1'b1;
          parent_r[free_idx_r] <= cur_pid;
          tstate_r[free_idx_r] <= ptps_pkg::TS_READY;
          nice_r[free_idx_r]   <= '0;
          ticks_r[free_idx_r]  <= ticks_r[cur_r];
          code_r[free_idx_r]   <= '0;
          live_r               <= live_r + PW'(1);
          new_pid_r            <= PW'(free_idx_r) + PW'(1);
        end
        ptps_pkg::CMD_EXIT: begin
          tstate_r[cur_r] <= ptps_pkg::TS_ZOMBIE;
          code_r[cur_r]   <= exit_code_r;
          if (live_r != '0) begin
            live_r <= live_r - PW'(1);
          end
          // A sleeping parent wakes at once and then looks for a zombie child.
          if (par_sleep) begin
            cur_r             <= par_idx;
            tstate_r[par_idx] <= ptps_pkg::TS_RUN;
          end
          idx_r        <= '0;
          free_found_r <= 1'b0;
          zomb_found_r <= 1'b0;
          has_child_r  <= 1'b0;
          best_r       <= '0;
          pick_found_r <= 1'b0;
        end
        ptps_pkg::CMD_REAP: begin
          valid_r[zomb_idx_r]  <= 1'b0;
          reaped_pid_r         <= PW'(zomb_idx_r) + PW'(1);
          reaped_code_r        <= code_r[zomb_idx_r];
        end
        ptps_pkg::CMD_SLEEP: begin
          tstate_r[cur_r] <= ptps_pkg::TS_SLEEP;
          idx_r           <= '0;
          best_r          <= '0;
          pick_found_r    <= 1'b0;
        end
        ptps_pkg::CMD_NICE: begin
          if (nv_r > ptps_pkg::NICE_MAX) begin
            nice_r[cur_r] <= 6'(ptps_pkg::NICE_MAX);
          end else if (nv_r < ptps_pkg::NICE_MIN) begin
            nice_r[cur_r] <= 6'(ptps_pkg::NICE_MIN);
          end else begin
            nice_r[cur_r] <= 6'(nv_r);
          end
        end
        ptps_pkg::CMD_RS_CLR: begin
          idx_r        <= '0;
          best_r       <= '0;
          pick_found_r <= 1'b0;
        end
        ptps_pkg::CMD_RS_NEXT: begin
          idx_r <= idx_r + SW'(1);
        end
        ptps_pkg::CMD_DIV_START: begin
          dvd_r  <= ticks_r[idx_r];
          rem_r  <= '0;
          cnt_r  <= '0;
          base_r <= 6'(base_wide);
        end
        ptps_pkg::CMD_DIV_STEP: begin
          // One quotient bit per cycle, restoring division.
          if (trial >= {1'b0, base_r}) begin
            rem_r <= trial - {1'b0, base_r};
            dvd_r <= {dvd_r[TICK_WIDTH-2:0], 1'b1};
          end else begin
            rem_r <= trial;
            dvd_r <= {dvd_r[TICK_WIDTH-2:0], 1'b0};
          end
          cnt_r <= cnt_r + CW'(1);
        end
        ptps_pkg::CMD_PRIO: begin
          if (eligible && prio > best_r) begin
            best_r       <= prio;
            pick_found_r <= 1'b1;
            pick_r       <= idx_r;
          end
          idx_r <= idx_r + SW'(1);
        end
        ptps_pkg::CMD_APPLY: begin
          if (pick_found_r) begin
            if (pick_r != cur_r && tstate_r[cur_r] == ptps_pkg::TS_RUN) begin
              tstate_r[cur_r] <= ptps_pkg::TS_READY;
            end
            cur_r            <= pick_r;
            tstate_r[pick_r] <= ptps_pkg::TS_RUN;
          end
        end
        ptps_pkg::CMD_EMIT: begin
          out_valid_r  <= 1'b1;
          o_status_r   <= st_r;
          o_new_r      <= 5'(new_pid_r);
          o_rpid_r     <= 5'(reaped_pid_r);
          o_rcode_r    <= reaped_code_r;
          o_rpid_cur_r <= cur_ok ? 5'(cur_pid) : 5'd0;
          o_rpar_r     <= cur_ok ? 5'(par) : 5'd0;
          o_sw_r       <= (cur_r != before_r);
          o_gt_r       <= 32'(gt_r);
          o_rt_r       <= cur_ok ? 32'(ticks_r[cur_r]) : 32'd0;
          o_live_r     <= 5'(live_r);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_new_pid        = o_new_r;
  assign out_reaped_pid     = o_rpid_r;
  assign out_reaped_code    = o_rcode_r;
  assign out_running_pid    = o_rpid_cur_r;
  assign out_running_parent = o_rpar_r;
  assign out_switched       = o_sw_r;
  assign out_all_ticks      = o_gt_r;
  assign out_running_ticks  = o_rt_r;
  assign out_live_tasks     = o_live_r;

endmodule
`default_nettype wire
